// ===== rtl/gemv_scale_accumulate_top_defines.svh =====
// Assertion macros for the gemv_scale_accumulate RTL.
`ifndef GEMV_SCALE_ACCUMULATE_TOP_DEFINES_SVH
`define GEMV_SCALE_ACCUMULATE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GSA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gsa_pkg.sv =====
// Shared types, constants and helpers for the scaled matrix-vector unit.
package gsa_pkg;

    localparam int MAX_DIM     = 256;
    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int DIM_REG_W   = 9;
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [IDX_W-1:0]  addr_t;
    typedef logic [QPTR_W-1:0] qptr_t;
    typedef logic [QCNT_W-1:0] qcnt_t;

    localparam logic [1:0] CMD_LOAD_X = 2'd0;
    localparam logic [1:0] CMD_LOAD_Y = 2'd1;
    localparam logic [1:0] CMD_MATRIX = 2'd2;
    localparam logic [1:0] CMD_READ_Y = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA      = 3'd4;

    localparam logic signed [31:0] SAT_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN   = 32'sh8000_0000;
    localparam logic signed [63:0] WIDE_LIM  = 64'sh0001_0000_0000_0000;
    localparam logic signed [63:0] WIDE_LIMN = -64'sh0001_0000_0000_0000;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [7:0]         elem_index;
        logic signed [31:0] elem_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         out_index;
        logic signed [31:0] out_value;
        logic               saturated;
    } out_item_t;

    typedef struct packed {
        logic                 transpose;
        logic [DIM_REG_W-1:0] row_count;
        logic [DIM_REG_W-1:0] col_count;
        logic signed [31:0]   alpha_gain;
        logic signed [31:0]   beta_gain;
    } cfg_t;

    typedef enum logic [2:0] {
        OP_LOAD_X  = 3'd0,
        OP_LOAD_Y  = 3'd1,
        OP_SCALE_Y = 3'd2,
        OP_READ_Y  = 3'd3,
        OP_DOT     = 3'd4,
        OP_AXPY    = 3'd5
    } op_t;

    typedef struct packed {
        op_t                op;
        addr_t              x_addr;
        addr_t              y_addr;
        logic [7:0]         idx;
        logic signed [31:0] value;
        logic               row_end;
        logic               in_range;
    } entry_t;

    // Last valid position for a dimension register: 0 acts as 1, clipped to MAX_DIM.
    function automatic addr_t dim_last(input logic [DIM_REG_W-1:0] count);
        int v;
        v = int'(count);
        if (v == 0)
            v = 1;
        if (v > MAX_DIM)
            v = MAX_DIM;
        return addr_t'(v - 1);
    endfunction

endpackage

// ===== rtl/gsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/gsa_front.sv =====
// Front end: accepts commands, tracks matrix position, classifies into queue entries.
module gsa_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  gsa_pkg::in_item_t item,
    input  gsa_pkg::cfg_t     cfg,
    input  logic              full,
    output logic              busy,
    output logic              push,
    output gsa_pkg::entry_t   entry
);

    gsa_pkg::addr_t row_pos_reg, row_pos_next;
    gsa_pkg::addr_t col_pos_reg, col_pos_next;
    gsa_pkg::addr_t m_last, n_last, r_pos, c_pos, idx_addr;
    logic           accept, in_range, row_end;

    assign busy   = full;
    assign accept = start && !full;

    always_comb
    begin
        m_last   = gsa_pkg::dim_last(cfg.row_count);
        n_last   = gsa_pkg::dim_last(cfg.col_count);
        r_pos    = (row_pos_reg > m_last) ? m_last : row_pos_reg;
        c_pos    = (col_pos_reg > n_last) ? n_last : col_pos_reg;
        row_end  = (c_pos == n_last);
        in_range = ({24'd0, item.elem_index} < 32'(gsa_pkg::MAX_DIM));
        idx_addr = gsa_pkg::addr_t'(item.elem_index);

        entry.op       = gsa_pkg::OP_LOAD_X;
        entry.x_addr   = idx_addr;
        entry.y_addr   = idx_addr;
        entry.idx      = item.elem_index;
        entry.value    = item.elem_value;
        entry.row_end  = row_end;
        entry.in_range = in_range;
        push           = accept && in_range;

        unique case (item.cmd)
            gsa_pkg::CMD_LOAD_X:
            begin
                entry.op = gsa_pkg::OP_LOAD_X;
            end
            gsa_pkg::CMD_LOAD_Y:
            begin
                entry.op = cfg.transpose ? gsa_pkg::OP_SCALE_Y : gsa_pkg::OP_LOAD_Y;
            end
            gsa_pkg::CMD_MATRIX:
            begin
                entry.op     = cfg.transpose ? gsa_pkg::OP_AXPY : gsa_pkg::OP_DOT;
                entry.x_addr = cfg.transpose ? r_pos : c_pos;
                entry.y_addr = cfg.transpose ? c_pos : r_pos;
                push         = accept;
            end
            gsa_pkg::CMD_READ_Y:
            begin
                entry.op = gsa_pkg::OP_READ_Y;
                push     = accept;
            end
        endcase

        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        if (accept && item.cmd == gsa_pkg::CMD_MATRIX)
        begin
            if (row_end)
            begin
                col_pos_next = '0;
                row_pos_next = (r_pos == m_last) ? '0 : r_pos + 1'b1;
            end
            else
            begin
                col_pos_next = c_pos + 1'b1;
                row_pos_next = r_pos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
        end
        else
        begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
        end
    end

endmodule

// ===== rtl/gsa_queue.sv =====
// Small FIFO of classified entries between front end and execution unit.
module gsa_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gsa_pkg::entry_t entry,
    input  logic            pop,
    output gsa_pkg::entry_t head,
    output logic            full,
    output logic            empty
);

    gsa_pkg::entry_t slot_reg [gsa_pkg::QUEUE_DEPTH];
    gsa_pkg::qptr_t  wr_ptr_reg, wr_ptr_next;
    gsa_pkg::qptr_t  rd_ptr_reg, rd_ptr_next;
    gsa_pkg::qcnt_t  count_reg, count_next;

    function automatic gsa_pkg::qptr_t ptr_inc(input gsa_pkg::qptr_t p);
        return (p == gsa_pkg::qptr_t'(gsa_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full  = (count_reg == gsa_pkg::qcnt_t'(gsa_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

// ===== rtl/gsa_back.sv =====
// Execution unit: vector stores, shared 33x33 multiplier, accumulate and saturate.
`include "gemv_scale_accumulate_top_defines.svh"

module gsa_back (
    input  logic               clk,
    input  logic               rst_n,
    input  gsa_pkg::cfg_t      cfg,
    input  gsa_pkg::entry_t    head,
    input  logic               empty,
    output logic               pop,
    output logic               done,
    output gsa_pkg::out_item_t result
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL0 = 9'b000000010,
        S_ACC  = 9'b000000100,
        S_TMP  = 9'b000001000,
        S_WLO  = 9'b000010000,
        S_WHI  = 9'b000100000,
        S_WSUM = 9'b001000000,
        S_SAT  = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

    state_t                 state_reg, state_next;
    gsa_pkg::entry_t        cur_reg, cur_next;
    logic signed [63:0]     acc_reg, acc_next;
    logic                   clip_reg, clip_next;
    logic signed [65:0]     mul_reg, mul_next;
    logic signed [65:0]     lo_reg, lo_next;
    logic signed [63:0]     wide_reg, wide_next;
    logic signed [63:0]     addend_reg, addend_next;
    logic signed [49:0]     clamp_reg, clamp_next;

    logic signed [32:0]     mul_a, mul_b;
    logic signed [63:0]     prod_q;
    logic signed [97:0]     wide_full, wide_sh;
    logic signed [65:0]     sum_total;
    logic signed [31:0]     sat_value;
    logic                   sat_clip;

    logic                   x_we, y_we;
    gsa_pkg::addr_t         y_waddr;
    logic [31:0]            y_wdata;
    logic [31:0]            x_rd, y_rd;

    gsa_ram #(.WIDTH(32), .DEPTH(gsa_pkg::MAX_DIM)) u_x_ram (
        .clk   (clk),
        .we    (x_we),
        .waddr (head.x_addr),
        .wdata (head.value),
        .re    (pop),
        .raddr (head.x_addr),
        .rdata (x_rd)
    );

    gsa_ram #(.WIDTH(32), .DEPTH(gsa_pkg::MAX_DIM)) u_y_ram (
        .clk   (clk),
        .we    (y_we),
        .waddr (y_waddr),
        .wdata (y_wdata),
        .re    (pop),
        .raddr (head.y_addr),
        .rdata (y_rd)
    );

    // floor(product / 2^16)
    assign prod_q    = 64'(mul_reg >>> 16);
    assign wide_full = (98'(mul_reg) <<< 32) + 98'(lo_reg);
    assign wide_sh   = wide_full >>> 16;
    assign mul_next  = mul_a * mul_b;

    always_comb
    begin
        sum_total = (cur_reg.op == gsa_pkg::OP_SCALE_Y) ? 66'(prod_q)
                                                        : 66'(clamp_reg) + 66'(addend_reg);
        sat_clip  = 1'b0;
        sat_value = 32'(sum_total);
        if (sum_total > 66'(gsa_pkg::SAT_MAX))
        begin
            sat_value = gsa_pkg::SAT_MAX;
            sat_clip  = 1'b1;
        end
        else if (sum_total < 66'(gsa_pkg::SAT_MIN))
        begin
            sat_value = gsa_pkg::SAT_MIN;
            sat_clip  = 1'b1;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        acc_next    = acc_reg;
        clip_next   = clip_reg;
        lo_next     = lo_reg;
        wide_next   = wide_reg;
        addend_next = addend_reg;
        clamp_next  = clamp_reg;
        mul_a       = '0;
        mul_b       = '0;
        pop         = 1'b0;
        x_we        = 1'b0;
        y_we        = 1'b0;
        y_waddr     = head.y_addr;
        y_wdata     = head.value;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    cur_next = head;
                    x_we     = (head.op == gsa_pkg::OP_LOAD_X);
                    y_we     = (head.op == gsa_pkg::OP_LOAD_Y);
                    unique case (head.op)
                        gsa_pkg::OP_READ_Y:  state_next = S_OUT;
                        gsa_pkg::OP_SCALE_Y: state_next = S_MUL0;
                        gsa_pkg::OP_DOT:     state_next = S_MUL0;
                        gsa_pkg::OP_AXPY:    state_next = S_MUL0;
                        default:             state_next = S_IDLE;
                    endcase
                end
            end
            S_MUL0:
            begin
                mul_a = 33'(cur_reg.value);
                if (cur_reg.op == gsa_pkg::OP_SCALE_Y)
                begin
                    mul_b      = 33'(cfg.beta_gain);
                    state_next = S_SAT;
                end
                else
                begin
                    mul_b      = 33'($signed(x_rd));
                    state_next = (cur_reg.op == gsa_pkg::OP_DOT) ? S_ACC : S_TMP;
                end
            end
            S_ACC:
            begin
                // beta*y[row] goes into the multiplier while the sum settles
                mul_a = 33'(cfg.beta_gain);
                mul_b = 33'($signed(y_rd));
                if (cur_reg.row_end)
                begin
                    wide_next  = acc_reg + prod_q;
                    acc_next   = '0;
                    state_next = S_WLO;
                end
                else
                begin
                    acc_next   = acc_reg + prod_q;
                    state_next = S_IDLE;
                end
            end
            S_TMP:
            begin
                wide_next   = prod_q;
                addend_next = 64'($signed(y_rd));
                state_next  = S_WLO;
            end
            S_WLO:
            begin
                mul_a = {1'b0, wide_reg[31:0]};
                mul_b = 33'(cfg.alpha_gain);
                if (cur_reg.op == gsa_pkg::OP_DOT)
                begin
                    addend_next = prod_q;
                end
                state_next = S_WHI;
            end
            S_WHI:
            begin
                mul_a      = 33'($signed(wide_reg[63:32]));
                mul_b      = 33'(cfg.alpha_gain);
                lo_next    = mul_reg;
                state_next = S_WSUM;
            end
            S_WSUM:
            begin
                if (wide_sh > 98'(gsa_pkg::WIDE_LIM))
                begin
                    clamp_next = 50'(gsa_pkg::WIDE_LIM);
                end
                else if (wide_sh < 98'(gsa_pkg::WIDE_LIMN))
                begin
                    clamp_next = 50'(gsa_pkg::WIDE_LIMN);
                end
                else
                begin
                    clamp_next = 50'(wide_sh);
                end
                state_next = S_SAT;
            end
            S_SAT:
            begin
                y_we       = 1'b1;
                y_waddr    = cur_reg.y_addr;
                y_wdata    = sat_value;
                clip_next  = clip_reg | sat_clip;
                state_next = S_IDLE;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done              = (state_reg == S_OUT);
    assign result.out_index  = cur_reg.idx;
    assign result.out_value  = cur_reg.in_range ? $signed(y_rd) : '0;
    assign result.saturated  = clip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            acc_reg   <= '0;
            clip_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            clip_reg  <= clip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        mul_reg    <= mul_next;
        lo_reg     <= lo_next;
        wide_reg   <= wide_next;
        addend_reg <= addend_next;
        clamp_reg  <= clamp_next;
    end

    `GSA_ASSERT_NEXT(a_done_single, done, !done, "result strobe held past one cycle")
    `GSA_ASSERT_NEXT(a_acc_clear, (state_reg == S_ACC) && cur_reg.row_end, acc_reg == '0, "accumulator not cleared at row end")
    `GSA_ASSERT_SAME(a_clip_sticky, 1'b1, !$fell(clip_reg), "sticky clip flag dropped")
    `GSA_ASSERT_NEXT(a_load_fast, pop && (head.op == gsa_pkg::OP_LOAD_X || head.op == gsa_pkg::OP_LOAD_Y), state_reg == S_IDLE, "plain load did not finish in one cycle")

endmodule

// ===== rtl/gemv_scale_accumulate_top.sv =====
// Top level of the scaled matrix-vector unit: configuration registers and wiring.
// An idle unit pops a read from the queue and returns it on done in state S_OUT.
// States per item: load S_IDLE; transposed y load MUL0, SAT; read OUT; matrix element
// MUL0, ACC, and WLO, WHI, WSUM, SAT at a row end; transposed: MUL0, TMP, WLO to SAT.
// A two-entry queue decouples start from execution; busy is high while it is full.
// Reset clears counters, accumulator, clip flag; config gets defaults; stores stay unknown.
module gemv_scale_accumulate_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  gsa_pkg::in_item_t                 item,
    output logic                              done,
    output gsa_pkg::out_item_t                result,
    input  logic                              cfg_we,
    input  logic [gsa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                       cfg_data
);

    gsa_pkg::cfg_t   cfg_reg, cfg_next;
    gsa_pkg::entry_t push_entry, head;
    logic            push, pop, full, empty;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                gsa_pkg::CFG_TRANSPOSE: cfg_next.transpose  = cfg_data[0];
                gsa_pkg::CFG_ROW_COUNT: cfg_next.row_count  = cfg_data[gsa_pkg::DIM_REG_W-1:0];
                gsa_pkg::CFG_COL_COUNT: cfg_next.col_count  = cfg_data[gsa_pkg::DIM_REG_W-1:0];
                gsa_pkg::CFG_ALPHA:     cfg_next.alpha_gain = $signed(cfg_data);
                gsa_pkg::CFG_BETA:      cfg_next.beta_gain  = $signed(cfg_data);
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.transpose  <= 1'b0;
            cfg_reg.row_count  <= gsa_pkg::DIM_REG_W'(1);
            cfg_reg.col_count  <= gsa_pkg::DIM_REG_W'(1);
            cfg_reg.alpha_gain <= 32'sd65536;
            cfg_reg.beta_gain  <= 32'sd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gsa_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .cfg   (cfg_reg),
        .full  (full),
        .busy  (busy),
        .push  (push),
        .entry (push_entry)
    );

    gsa_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .entry (push_entry),
        .pop   (pop),
        .head  (head),
        .full  (full),
        .empty (empty)
    );

    gsa_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

endmodule
